### hdl/rps_pkg.sv
`default_nettype none

package rps_pkg;

  // Field widths that the channels fix.
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned PART_W = 16;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CFG_W  = 6;

  // Reset value of the member count register.
  localparam logic [CFG_W-1:0] MEMBER_COUNT_RESET = CFG_W'(1);

  // One classified topic, handed from the front end to the back end.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [PART_W-1:0] base;
    logic [CFG_W-1:0]  extra;
    logic [CFG_W-1:0]  members;
  } job_t;

endpackage

`default_nettype wire

### hdl/rps_if.sv
`default_nettype none

// Input channel: one topic per item.
interface rps_in_if;
  logic                       valid;
  logic                       ready;
  logic [rps_pkg::TAG_W-1:0]  topic_tag;
  logic [rps_pkg::PART_W-1:0] partition_total;

  modport source (output valid, output topic_tag, output partition_total, input ready);
  modport sink   (input valid, input topic_tag, input partition_total, output ready);
endinterface

// Output channel: one member range per item.
interface rps_out_if;
  logic                       valid;
  logic                       ready;
  logic [rps_pkg::TAG_W-1:0]  topic_tag_out;
  logic [rps_pkg::IDX_W-1:0]  member_index;
  logic [rps_pkg::PART_W-1:0] first_partition;
  logic [rps_pkg::LEN_W-1:0]  range_length;
  logic                       last_member;

  modport source (output valid, output topic_tag_out, output member_index,
                  output first_partition, output range_length, output last_member,
                  input ready);
  modport sink   (input valid, input topic_tag_out, input member_index,
                  input first_partition, input range_length, input last_member,
                  output ready);
endinterface

`default_nettype wire

### hdl/rps_front.sv
`default_nettype none

module rps_front #(
  parameter int unsigned MAX_MEMBERS = 32,
  parameter int unsigned PART_WIDTH  = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [rps_pkg::CFG_W-1:0] member_count_i,
  rps_in_if.sink                         in_i,
  output      logic                      push_valid_o,
  input  wire logic                      push_ready_i,
  output      rps_pkg::job_t             push_job_o
);

  localparam int unsigned CW   = rps_pkg::CFG_W;
  localparam int unsigned CNTW = $clog2(PART_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } state_e;

  state_e                       state_q, state_d;
  logic [rps_pkg::TAG_W-1:0]    tag_q, tag_d;
  logic [PART_WIDTH-1:0]        quo_q, quo_d;
  logic [CW-1:0]                rem_q, rem_d;
  logic [CW-1:0]                div_q, div_d;
  logic [CNTW-1:0]              cnt_q, cnt_d;

  logic [CW-1:0]                members_eff;
  logic [CW:0]                  shifted;
  logic                         accept;

  // Saturate the member count at the configured maximum.
  always_comb begin
    if ({1'b0, member_count_i} > (CW+1)'(MAX_MEMBERS)) begin
      members_eff = CW'(MAX_MEMBERS);
    end else begin
      members_eff = member_count_i;
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // One restoring division step: bring down the next dividend bit.
  assign shifted = {rem_q, quo_q[PART_WIDTH-1]};

  always_comb begin
    state_d = state_q;
    tag_d   = tag_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    div_d   = div_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        // An item with no members is consumed and dropped here.
        if (accept && (members_eff != '0)) begin
          tag_d   = in_i.topic_tag;
          quo_d   = in_i.partition_total[PART_WIDTH-1:0];
          rem_d   = '0;
          div_d   = members_eff;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (shifted >= {1'b0, div_q}) begin
          rem_d = CW'(shifted - {1'b0, div_q});
          quo_d = {quo_q[PART_WIDTH-2:0], 1'b1};
        end else begin
          rem_d = shifted[CW-1:0];
          quo_d = {quo_q[PART_WIDTH-2:0], 1'b0};
        end
        cnt_d = cnt_q + CNTW'(1);
        if (cnt_q == CNTW'(PART_WIDTH - 1)) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  // Quotient is the base range length, remainder the count of longer ranges.
  assign push_valid_o       = (state_q == ST_PUSH);
  assign push_job_o.tag     = tag_q;
  assign push_job_o.base    = rps_pkg::PART_W'(quo_q);
  assign push_job_o.extra   = rem_q;
  assign push_job_o.members = div_q;

endmodule

`default_nettype wire

### hdl/rps_queue.sv
`default_nettype none

module rps_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output      logic          push_ready_o,
  input  wire rps_pkg::job_t push_job_i,
  output      logic          pop_valid_o,
  input  wire logic          pop_ready_i,
  output      rps_pkg::job_t pop_job_o
);

  localparam int unsigned DEPTH = 2;

  rps_pkg::job_t    mem_q [DEPTH];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (count_q != 2'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage for the queued jobs.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

### hdl/rps_back.sv
`default_nettype none

module rps_back #(
  parameter int unsigned PART_WIDTH = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          pop_valid_i,
  output      logic          pop_ready_o,
  input  wire rps_pkg::job_t pop_job_i,
  rps_out_if.source          out_o
);

  localparam int unsigned CW = rps_pkg::CFG_W;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e                      state_q, state_d;
  rps_pkg::job_t               job_q, job_d;
  logic [CW-1:0]               idx_q, idx_d;
  logic [PART_WIDTH-1:0]       start_q, start_d;

  logic                        ovalid_q, ovalid_d;
  logic [rps_pkg::TAG_W-1:0]   otag_q, otag_d;
  logic [rps_pkg::IDX_W-1:0]   oidx_q, oidx_d;
  logic [rps_pkg::PART_W-1:0]  ofirst_q, ofirst_d;
  logic [rps_pkg::LEN_W-1:0]   olen_q, olen_d;
  logic                        olast_q, olast_d;

  logic                        advance;
  logic                        is_last;
  logic [PART_WIDTH-1:0]       count;

  // The output register may be refilled when empty or being taken.
  assign advance     = !ovalid_q || out_o.ready;
  assign pop_ready_o = (state_q == ST_IDLE);

  // Range length of the current member and whether it closes the run.
  assign count   = job_q.base[PART_WIDTH-1:0] + PART_WIDTH'(idx_q < job_q.extra);
  assign is_last = (({1'b0, idx_q} + (CW+1)'(1)) == {1'b0, job_q.members});

  always_comb begin
    state_d  = state_q;
    job_d    = job_q;
    idx_d    = idx_q;
    start_d  = start_q;
    ovalid_d = ovalid_q && !out_o.ready;
    otag_d   = otag_q;
    oidx_d   = oidx_q;
    ofirst_d = ofirst_q;
    olen_d   = olen_q;
    olast_d  = olast_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          job_d   = pop_job_i;
          idx_d   = '0;
          start_d = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (advance) begin
          ovalid_d = 1'b1;
          otag_d   = job_q.tag;
          oidx_d   = idx_q[rps_pkg::IDX_W-1:0];
          ofirst_d = rps_pkg::PART_W'(start_q);
          olen_d   = rps_pkg::LEN_W'(count);
          olast_d  = is_last;
          idx_d    = idx_q + CW'(1);
          start_d  = start_q + count;
          if (is_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    idx_q    <= idx_d;
    start_q  <= start_d;
    otag_q   <= otag_d;
    oidx_q   <= oidx_d;
    ofirst_q <= ofirst_d;
    olen_q   <= olen_d;
    olast_q  <= olast_d;
  end

  assign out_o.valid           = ovalid_q;
  assign out_o.topic_tag_out   = otag_q;
  assign out_o.member_index    = oidx_q;
  assign out_o.first_partition = ofirst_q;
  assign out_o.range_length    = olen_q;
  assign out_o.last_member     = olast_q;

endmodule

`default_nettype wire

### hdl/range_partition_splitter_core.sv
`default_nettype none

// Splits the partitions of each topic into contiguous ranges, one range per
// group member in member order, with the final range of a topic marked by
// last_member. The member count is written through cfg_we_i/cfg_wdata_i and
// saturates at MAX_MEMBERS; with a count of zero an item is consumed and gives
// no result. The front end divides the partition count by the member count
// with a one-bit-per-cycle divider. The back end loads each topic from the
// queue, then emits one result per cycle unless the output stalls.
// A two-entry queue between them lets both run at once. Results leave
// through a registered output.
module range_partition_splitter_core #(
  parameter int unsigned MAX_MEMBERS = 32,
  parameter int unsigned PART_WIDTH  = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [rps_pkg::CFG_W-1:0] cfg_wdata_i,
  rps_in_if.sink                         in_i,
  rps_out_if.source                      out_o
);

  logic [rps_pkg::CFG_W-1:0] member_count_q;
  logic                      push_valid;
  logic                      push_ready;
  rps_pkg::job_t             push_job;
  logic                      pop_valid;
  logic                      pop_ready;
  rps_pkg::job_t             pop_job;

  // Member count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_count_q <= rps_pkg::MEMBER_COUNT_RESET;
    end else if (cfg_we_i) begin
      member_count_q <= cfg_wdata_i;
    end
  end

  rps_front #(
    .MAX_MEMBERS (MAX_MEMBERS),
    .PART_WIDTH  (PART_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .member_count_i (member_count_q),
    .in_i           (in_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_job_o     (push_job)
  );

  rps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  rps_back #(
    .PART_WIDTH (PART_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

### hdl/rps_checker.sv
`default_nettype none

module rps_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [rps_pkg::TAG_W-1:0]   out_tag_i,
  input wire logic [rps_pkg::IDX_W-1:0]   out_index_i,
  input wire logic [rps_pkg::PART_W-1:0]  out_first_i,
  input wire logic [rps_pkg::LEN_W-1:0]   out_len_i,
  input wire logic                        out_last_i
);

  logic                        first_q;
  logic [rps_pkg::IDX_W-1:0]   exp_idx_q;
  logic [rps_pkg::PART_W-1:0]  next_start_q;
  logic                        out_take;

  assign out_take = out_valid_i && out_ready_i;

  // Track where the next result of a run must start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q      <= 1'b1;
      exp_idx_q    <= '0;
      next_start_q <= '0;
    end else if (out_take) begin
      first_q      <= out_last_i;
      exp_idx_q    <= out_last_i ? '0 : exp_idx_q + rps_pkg::IDX_W'(1);
      next_start_q <= out_first_i + out_len_i;
    end
  end

  // A result held back by the sink keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_tag_i) &&
      $stable(out_index_i) && $stable(out_first_i) && $stable(out_len_i) &&
      $stable(out_last_i))
    else $error("output item changed while stalled");

  // Members appear in order, starting from zero on every topic.
  a_index_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_index_i == exp_idx_q)
    else $error("member index out of sequence");

  // The first range of a topic starts at partition zero.
  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && first_q |-> out_first_i == '0)
    else $error("first range does not start at zero");

  // Each later range starts where the previous one ended.
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !first_q |-> out_first_i == next_start_q)
    else $error("ranges are not contiguous");

endmodule

bind range_partition_splitter_core rps_checker u_rps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_tag_i   (out_o.topic_tag_out),
  .out_index_i (out_o.member_index),
  .out_first_i (out_o.first_partition),
  .out_len_i   (out_o.range_length),
  .out_last_i  (out_o.last_member)
);

`default_nettype wire
